// File: design/pth_pkg.sv
`timescale 1ns / 1ps

package pth_pkg;

    localparam int TAB_STOP_DEF = 8;
    localparam int TAB_STOP_MAX = 16;
    localparam int CP_W         = 21;
    // Wide enough for a full tab expansion and the longest entity
    localparam int CNT_W        = $clog2(TAB_STOP_MAX + 1);
    localparam int QUEUE_DEPTH  = 2;

    // Output segments of one item, in emission order
    localparam int NSEG       = 5;
    localparam int SEG_OPEN   = 0;
    localparam int SEG_FLUSH  = 1;
    localparam int SEG_BODY   = 2;
    localparam int SEG_END    = 3;
    localparam int SEG_CLOSE  = 4;

    localparam logic [CP_W-1:0] CP_TAB  = 21'h000009;
    localparam logic [CP_W-1:0] CP_NL   = 21'h00000A;
    localparam logic [CP_W-1:0] CP_AMP  = 21'h000026;
    localparam logic [CP_W-1:0] CP_LT   = 21'h00003C;
    localparam logic [CP_W-1:0] CP_GT   = 21'h00003E;
    localparam logic [CP_W-1:0] CP_NBSP = 21'h0000A0;

    // Register word index (paddr[2])
    localparam logic REG_PRE_MODE = 1'b0;

    typedef enum logic [2:0] {
        STR_CP,
        STR_P,
        STR_CLOSE_P_NL,
        STR_BR_NL,
        STR_LT,
        STR_GT,
        STR_AMP,
        STR_CLOSE_P
    } str_t;

    typedef struct packed {
        logic [NSEG-1:0]  seg_mask;
        str_t             flush_str;
        str_t             body_str;
        logic [CP_W-1:0]  body_cp;
        logic [CNT_W-1:0] body_cnt;
        str_t             end_str;
        logic             eot;
    } desc_t;

    function automatic logic is_space(logic [CP_W-1:0] cp);
        return cp inside {[21'h000009:21'h00000D], 21'h000020, 21'h000085, 21'h0000A0,
                          21'h001680, [21'h002000:21'h00200A], 21'h002028, 21'h002029,
                          21'h00202F, 21'h00205F, 21'h003000};
    endfunction

    function automatic logic [CNT_W-1:0] str_len(str_t s, logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] len;
        case (s)
            STR_CP:         len = cnt;
            STR_P:          len = CNT_W'(3);
            STR_CLOSE_P_NL: len = CNT_W'(5);
            STR_BR_NL:      len = CNT_W'(5);
            STR_LT:         len = CNT_W'(4);
            STR_GT:         len = CNT_W'(4);
            STR_AMP:        len = CNT_W'(5);
            STR_CLOSE_P:    len = CNT_W'(4);
            default:        len = cnt;
        endcase
        return len;
    endfunction

    function automatic logic [CP_W-1:0] str_char(str_t s, logic [CNT_W-1:0] idx,
                                                 logic [CP_W-1:0] cp);
        logic [7:0] ch;
        ch = 8'h00;
        case (s)
            STR_P:
                case (idx)
                    CNT_W'(0): ch = 8'h3C;
                    CNT_W'(1): ch = 8'h70;
                    default:   ch = 8'h3E;
                endcase
            STR_CLOSE_P_NL:
                case (idx)
                    CNT_W'(0): ch = 8'h3C;
                    CNT_W'(1): ch = 8'h2F;
                    CNT_W'(2): ch = 8'h70;
                    CNT_W'(3): ch = 8'h3E;
                    default:   ch = 8'h0A;
                endcase
            STR_BR_NL:
                case (idx)
                    CNT_W'(0): ch = 8'h3C;
                    CNT_W'(1): ch = 8'h62;
                    CNT_W'(2): ch = 8'h72;
                    CNT_W'(3): ch = 8'h3E;
                    default:   ch = 8'h0A;
                endcase
            STR_LT:
                case (idx)
                    CNT_W'(0): ch = 8'h26;
                    CNT_W'(1): ch = 8'h6C;
                    CNT_W'(2): ch = 8'h74;
                    default:   ch = 8'h3B;
                endcase
            STR_GT:
                case (idx)
                    CNT_W'(0): ch = 8'h26;
                    CNT_W'(1): ch = 8'h67;
                    CNT_W'(2): ch = 8'h74;
                    default:   ch = 8'h3B;
                endcase
            STR_AMP:
                case (idx)
                    CNT_W'(0): ch = 8'h26;
                    CNT_W'(1): ch = 8'h61;
                    CNT_W'(2): ch = 8'h6D;
                    CNT_W'(3): ch = 8'h70;
                    default:   ch = 8'h3B;
                endcase
            STR_CLOSE_P:
                case (idx)
                    CNT_W'(0): ch = 8'h3C;
                    CNT_W'(1): ch = 8'h2F;
                    CNT_W'(2): ch = 8'h70;
                    default:   ch = 8'h3E;
                endcase
            default:
                ch = 8'h00;
        endcase
        if (s == STR_CP)
        begin
            return cp;
        end
        return {{(CP_W-8){1'b0}}, ch};
    endfunction

endpackage

// File: design/pth_front.sv
`timescale 1ns / 1ps

module pth_front #(
    parameter int TAB_STOP = pth_pkg::TAB_STOP_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pre_mode,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [pth_pkg::CP_W-1:0]   code_point,
    input  logic                       char_valid,
    input  logic                       end_of_text,
    input  logic                       q_full,
    output logic                       push,
    output pth_pkg::desc_t             desc
);

    localparam int COL_W = $clog2(TAB_STOP);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(TAB_STOP - 1);

    logic                        at_start_reg, at_start_next;
    logic [1:0]                  run_reg, run_next;
    logic [COL_W-1:0]            col_reg, col_next;
    logic                        nz_reg, nz_next;
    logic [COL_W-1:0]            col_base;
    logic                        accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && (desc.seg_mask != '0);

    always_comb
    begin
        desc           = '0;
        desc.flush_str = pth_pkg::STR_P;
        desc.body_str  = pth_pkg::STR_CP;
        desc.end_str   = pth_pkg::STR_P;
        desc.body_cp   = code_point;
        desc.body_cnt  = pth_pkg::CNT_W'(1);
        desc.eot       = end_of_text;
        at_start_next  = at_start_reg;
        run_next       = run_reg;
        col_next       = col_reg;
        nz_next        = nz_reg;
        col_base       = col_reg;

        if (char_valid || end_of_text)
        begin
            desc.seg_mask[pth_pkg::SEG_OPEN] = at_start_reg;
            at_start_next = 1'b0;
        end

        if (char_valid)
        begin
            if (code_point == pth_pkg::CP_NL)
            begin
                if (run_reg == 2'd0)
                begin
                    run_next = 2'd1;
                end
                else if (run_reg == 2'd1)
                begin
                    desc.seg_mask[pth_pkg::SEG_FLUSH] = 1'b1;
                    desc.flush_str = pth_pkg::STR_CLOSE_P_NL;
                    run_next = 2'd2;
                end
                else
                begin
                    desc.seg_mask[pth_pkg::SEG_FLUSH] = 1'b1;
                    desc.flush_str = pth_pkg::STR_BR_NL;
                end
                col_next = '0;
                nz_next  = 1'b0;
            end
            else
            begin
                // close a pending newline run before the character
                if (run_reg != 2'd0)
                begin
                    desc.seg_mask[pth_pkg::SEG_FLUSH] = 1'b1;
                    desc.flush_str = (run_reg == 2'd1) ? pth_pkg::STR_BR_NL : pth_pkg::STR_P;
                end
                run_next = 2'd0;
                desc.seg_mask[pth_pkg::SEG_BODY] = 1'b1;
                if (pre_mode && code_point == pth_pkg::CP_TAB)
                begin
                    desc.body_cp  = pth_pkg::CP_NBSP;
                    desc.body_cnt = pth_pkg::CNT_W'(TAB_STOP) - pth_pkg::CNT_W'(col_reg);
                    col_base      = '0;
                end
                else if (pre_mode && pth_pkg::is_space(code_point))
                begin
                    desc.body_cp = pth_pkg::CP_NBSP;
                end
                else if (code_point == pth_pkg::CP_LT)
                begin
                    desc.body_str = pth_pkg::STR_LT;
                end
                else if (code_point == pth_pkg::CP_GT)
                begin
                    desc.body_str = pth_pkg::STR_GT;
                end
                else if (code_point == pth_pkg::CP_AMP)
                begin
                    desc.body_str = pth_pkg::STR_AMP;
                end
                col_next = (col_base == COL_LAST) ? '0 : col_base + COL_W'(1);
                nz_next  = 1'b1;
            end
        end

        if (end_of_text)
        begin
            if (run_next != 2'd0)
            begin
                desc.seg_mask[pth_pkg::SEG_END] = 1'b1;
                desc.end_str = (run_next == 2'd1) ? pth_pkg::STR_BR_NL : pth_pkg::STR_P;
            end
            desc.seg_mask[pth_pkg::SEG_CLOSE] = nz_next;
            at_start_next = 1'b1;
            run_next      = 2'd0;
            col_next      = '0;
            nz_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            run_reg      <= 2'd0;
            col_reg      <= '0;
            nz_reg       <= 1'b0;
        end
        else if (accept)
        begin
            at_start_reg <= at_start_next;
            run_reg      <= run_next;
            col_reg      <= col_next;
            nz_reg       <= nz_next;
        end
    end

endmodule

// File: design/pth_queue.sv
`timescale 1ns / 1ps

module pth_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pth_pkg::desc_t  push_desc,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output pth_pkg::desc_t  head
);

    localparam int DEPTH = pth_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    pth_pkg::desc_t     mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("item pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: design/pth_back.sv
`timescale 1ns / 1ps

module pth_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  pth_pkg::desc_t             head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [pth_pkg::CP_W-1:0]   out_code_point,
    output logic                       last_of_item,
    output logic                       end_of_output
);

    logic [pth_pkg::NSEG-1:0]   done_reg, done_next;
    logic [pth_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    logic [pth_pkg::CP_W-1:0]   out_cp_reg;
    logic                       last_reg;
    logic                       eoo_reg;

    logic [pth_pkg::NSEG-1:0]   work;
    logic [pth_pkg::NSEG-1:0]   cur_oh;
    logic [pth_pkg::NSEG-1:0]   rest;
    pth_pkg::str_t              cur_str;
    logic [pth_pkg::CNT_W-1:0]  cur_len;
    logic [pth_pkg::CP_W-1:0]   cur_cp;
    logic                       last_char;
    logic                       item_last;
    logic                       load;
    logic                       emit;

    assign work   = head.seg_mask & ~done_reg;
    // lowest pending segment
    assign cur_oh = work & (~work + pth_pkg::NSEG'(1));
    assign rest   = work & ~cur_oh;

    always_comb
    begin
        if (work[pth_pkg::SEG_OPEN])
        begin
            cur_str = pth_pkg::STR_P;
        end
        else if (work[pth_pkg::SEG_FLUSH])
        begin
            cur_str = head.flush_str;
        end
        else if (work[pth_pkg::SEG_BODY])
        begin
            cur_str = head.body_str;
        end
        else if (work[pth_pkg::SEG_END])
        begin
            cur_str = head.end_str;
        end
        else
        begin
            cur_str = pth_pkg::STR_CLOSE_P;
        end
    end

    assign cur_len   = pth_pkg::str_len(cur_str, head.body_cnt);
    assign cur_cp    = pth_pkg::str_char(cur_str, idx_reg, head.body_cp);
    assign last_char = (idx_reg == cur_len - pth_pkg::CNT_W'(1));
    assign item_last = last_char && (rest == '0);

    assign load = !out_valid_reg || !out_stall;
    assign emit = head_valid && load;
    assign pop  = emit && item_last;

    always_comb
    begin
        done_next      = done_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            if (item_last)
            begin
                done_next = '0;
                idx_next  = '0;
            end
            else if (last_char)
            begin
                done_next = done_reg | cur_oh;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + pth_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cp_reg <= cur_cp;
            last_reg   <= item_last;
            eoo_reg    <= item_last && head.eot;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_code_point = out_cp_reg;
    assign last_of_item   = last_reg;
    assign end_of_output  = eoo_reg;

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head.seg_mask != '0))
        else $error("empty item reached the output sequencer");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ((done_reg & ~head.seg_mask) == '0))
        else $error("finished segment outside the item's segments");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && last_reg))
        else $error("item retired without its last result");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eoo_reg) |-> last_reg)
        else $error("end of output on a result that does not close its item");

endmodule

// File: design/plain_text_to_html_encoder_top.sv
`timescale 1ns / 1ps

// Plain text to HTML encoder. Each accepted item is classified in the front
// stage and, if it produces output, queued (two entries) for the output
// sequencer, which sends one code point per cycle while out_stall is low. An
// item producing k code points occupies the sequencer until all k are sent
// (1 for a plain character, up to 9 + TAB_STOP for a tab or end of text);
// items producing nothing are accepted but never reach the queue. The input
// stalls only while the queue is full, so a stream of ordinary characters
// flows at one item per cycle while out_stall is low. pre_mode sits at byte
// address 0; write it only while no items are in flight.

module plain_text_to_html_encoder_top #(
    parameter int TAB_STOP = pth_pkg::TAB_STOP_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [pth_pkg::CP_W-1:0]   code_point,
    input  logic                       char_valid,
    input  logic                       end_of_text,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [pth_pkg::CP_W-1:0]   out_code_point,
    output logic                       last_of_item,
    output logic                       end_of_output
);

    logic            pre_mode_reg;
    logic            q_full;
    logic            q_push;
    pth_pkg::desc_t  q_push_desc;
    logic            q_pop;
    logic            q_head_valid;
    pth_pkg::desc_t  q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pth_pkg::REG_PRE_MODE) ? {31'b0, pre_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == pth_pkg::REG_PRE_MODE)
        begin
            pre_mode_reg <= pwdata[0];
        end
    end

    pth_front #(
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pre_mode    (pre_mode_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_point  (code_point),
        .char_valid  (char_valid),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (q_push),
        .desc        (q_push_desc)
    );

    pth_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    pth_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head           (q_head),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_code_point (out_code_point),
        .last_of_item   (last_of_item),
        .end_of_output  (end_of_output)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CP_W          = pth_pkg::CP_W;
    localparam int TAB_COLS      = pth_pkg::TAB_STOP_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_MAX    = 10;
    localparam logic [2:0] ADDR_PRE_MODE = {pth_pkg::REG_PRE_MODE, 2'b00};

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
        logic            eoo;
    } html_cp_t;

    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_ONE,
        RUN_MANY
    } nl_run_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [CP_W-1:0] code_point = '0;
    logic            char_valid = 1'b0;
    logic            end_of_text = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CP_W-1:0] out_code_point;
    logic            last_of_item;
    logic            end_of_output;

    // Encoder state as the predictor sees it
    logic    pre_mode_model = 1'b0;
    logic    text_fresh = 1'b1;
    nl_run_t nl_pending = RUN_NONE;
    int      tab_col = 0;
    logic    line_used = 1'b0;

    html_cp_t html_expected[$];
    html_cp_t html_got;
    html_cp_t html_want;

    bit send_calm = 1'b0;
    bit sink_calm = 1'b0;
    int sink_hold = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int texts_done = 0;
    int html_checked = 0;

    plain_text_to_html_encoder_top #(
        .TAB_STOP(TAB_COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .code_point(code_point),
        .char_valid(char_valid),
        .end_of_text(end_of_text),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_code_point(out_code_point),
        .last_of_item(last_of_item),
        .end_of_output(end_of_output)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, html_expected.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_wait(bit calm);
        if (calm)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1, 2:    return $urandom_range(1, 3);
            default: return $urandom_range(0, 13);
        endcase
    endfunction

    function automatic bit is_blank(logic [CP_W-1:0] c);
        return (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == 21'h85
            || c == pth_pkg::CP_NBSP || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A)
            || c == 21'h2028 || c == 21'h2029 || c == 21'h202F || c == 21'h205F
            || c == 21'h3000;
    endfunction

    function automatic void emit_cp(logic [CP_W-1:0] c);
        html_cp_t r;
        r.cp = c;
        r.last = 1'b0;
        r.eoo = 1'b0;
        html_expected.push_back(r);
    endfunction

    function automatic void emit_str(string s);
        for (int i = 0; i < s.len(); i++)
            emit_cp(CP_W'(s[i]));
    endfunction

    // Close a pending newline run: a lone newline becomes a line break,
    // a longer run reopens the paragraph
    function automatic void close_newline_run();
        if (nl_pending == RUN_ONE)
            emit_str("<br>\n");
        else if (nl_pending == RUN_MANY)
            emit_str("<p>");
        nl_pending = RUN_NONE;
    endfunction

    function automatic void predict_html(logic [CP_W-1:0] c, logic cv, logic eot);
        int first;
        first = html_expected.size();
        if (!cv && !eot)
            return;
        if (text_fresh)
        begin
            emit_str("<p>");
            text_fresh = 1'b0;
        end
        if (cv)
        begin
            if (c == pth_pkg::CP_NL)
            begin
                case (nl_pending)
                    RUN_NONE: nl_pending = RUN_ONE;
                    RUN_ONE:
                    begin
                        emit_str("</p>\n");
                        nl_pending = RUN_MANY;
                    end
                    default:  emit_str("<br>\n");
                endcase
                tab_col = 0;
                line_used = 1'b0;
            end
            else
            begin
                close_newline_run();
                if (pre_mode_model && c == pth_pkg::CP_TAB)
                begin
                    repeat (TAB_COLS - tab_col) emit_cp(pth_pkg::CP_NBSP);
                    tab_col = 0;
                end
                else if (pre_mode_model && is_blank(c))
                    emit_cp(pth_pkg::CP_NBSP);
                else if (c == pth_pkg::CP_LT)
                    emit_str("&lt;");
                else if (c == pth_pkg::CP_GT)
                    emit_str("&gt;");
                else if (c == pth_pkg::CP_AMP)
                    emit_str("&amp;");
                else
                    emit_cp(c);
                // the tab keeps its extra column
                tab_col = (tab_col + 1) % TAB_COLS;
                line_used = 1'b1;
            end
        end
        if (eot)
        begin
            close_newline_run();
            if (line_used)
                emit_str("</p>");
            text_fresh = 1'b1;
            nl_pending = RUN_NONE;
            tab_col = 0;
            line_used = 1'b0;
        end
        if (html_expected.size() > first)
        begin
            html_expected[html_expected.size() - 1].last = 1'b1;
            html_expected[html_expected.size() - 1].eoo = eot;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            html_got.cp = out_code_point;
            html_got.last = last_of_item;
            html_got.eoo = end_of_output;
            html_checked++;
            if (html_expected.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: cp=%h last=%b end=%b",
                             html_got.cp, html_got.last, html_got.eoo);
            end
            else
            begin
                html_want = html_expected.pop_front();
                if (html_got.cp !== html_want.cp || html_got.last !== html_want.last
                    || html_got.eoo !== html_want.eoo)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch at result %0d: cp %h/%h last %b/%b end %b/%b",
                                 html_checked, html_want.cp, html_got.cp, html_want.last,
                                 html_got.last, html_want.eoo, html_got.eoo);
                end
            end
            sink_hold = draw_wait(sink_calm);
        end
        else if (sink_hold > 0)
            sink_hold--;
        out_stall <= (sink_hold > 0);
    end

    task automatic send_html_item(logic [CP_W-1:0] c, logic cv, logic eot);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        code_point  <= c;
        char_valid  <= cv;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_html(c, cv, eot);
        if (cv || eot)
            items_sent++;
        if (eot)
            texts_done++;
    endtask

    // Drop valid and wait out every expected result plus the front stage
    task automatic wait_html_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (html_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pre_mode(logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PRE_MODE;
        pwdata  <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pre_mode_model = value;
    endtask

    function automatic logic [CP_W-1:0] pick_char();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: return CP_W'($urandom_range(21'h21, 21'h7E));
            7:
            begin
                case ($urandom_range(0, 2))
                    0:       return pth_pkg::CP_LT;
                    1:       return pth_pkg::CP_GT;
                    default: return pth_pkg::CP_AMP;
                endcase
            end
            8, 9:  return pth_pkg::CP_NL;
            10:    return pth_pkg::CP_TAB;
            11:    return 21'h20;
            12:
            begin
                case ($urandom_range(0, 7))
                    0:       return 21'h0085;
                    1:       return pth_pkg::CP_NBSP;
                    2:       return 21'h1680;
                    3:       return CP_W'($urandom_range(21'h2000, 21'h200A));
                    4:       return CP_W'($urandom_range(21'h2028, 21'h2029));
                    5:       return 21'h202F;
                    6:       return 21'h205F;
                    default: return 21'h3000;
                endcase
            end
            13:    return CP_W'($urandom_range(21'h09, 21'h0D));
            14:    return CP_W'($urandom_range(21'h80, 21'hFFFF));
            15:    return CP_W'($urandom_range(0, 21'h1FFFFF));
            16:    return CP_W'($urandom_range(21'hD800, 21'hDFFF));
            17:    return CP_W'($urandom_range(21'h10000, 21'h10FFFF));
            default: return CP_W'($urandom_range(21'h61, 21'h7A));
        endcase
    endfunction

    task automatic send_random_text();
        int len;
        logic [CP_W-1:0] c;
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++)
        begin
            // idle item with junk on the code point
            if ($urandom_range(0, 11) == 0)
                send_html_item(CP_W'($urandom_range(0, 21'h1FFFFF)), 1'b0, 1'b0);
            c = pick_char();
            if (c == pth_pkg::CP_NL && $urandom_range(0, 1) == 1)
                repeat ($urandom_range(2, 4)) send_html_item(pth_pkg::CP_NL, 1'b1, 1'b0);
            else
                send_html_item(c, 1'b1, 1'b0);
        end
        if ($urandom_range(0, 1) == 1)
            send_html_item(pick_char(), 1'b1, 1'b1);
        else
            send_html_item(CP_W'($urandom_range(0, 21'h1FFFFF)), 1'b0, 1'b1);
    endtask

    task automatic test_escapes_and_extremes();
        send_html_item('0, 1'b0, 1'b1);
        send_html_item(21'h1FFFFF, 1'b0, 1'b0);
        send_html_item(pth_pkg::CP_LT, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_GT, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_AMP, 1'b1, 1'b0);
        send_html_item(21'h1FFFFF, 1'b1, 1'b0);
        send_html_item(21'h00D800, 1'b1, 1'b1);
    endtask

    task automatic test_newline_runs();
        send_html_item(21'h61, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_NL, 1'b1, 1'b0);
        send_html_item(21'h62, 1'b1, 1'b0);
        repeat (4) send_html_item(pth_pkg::CP_NL, 1'b1, 1'b0);
        send_html_item(21'h63, 1'b1, 1'b1);
        // run still open at end of text
        send_html_item(21'h78, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_NL, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_NL, 1'b1, 1'b0);
        send_html_item('0, 1'b0, 1'b1);
    endtask

    task automatic test_preformatted();
        wait_html_drained();
        write_pre_mode(1'b1);
        send_html_item(21'h61, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_TAB, 1'b1, 1'b0);
        send_html_item(21'h3000, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_NL, 1'b1, 1'b0);
        // line break, full tab and paragraph close from one item
        send_html_item(pth_pkg::CP_TAB, 1'b1, 1'b1);
        // switch mode in the middle of a text
        send_html_item(21'h71, 1'b1, 1'b0);
        send_html_item(pth_pkg::CP_TAB, 1'b1, 1'b0);
        wait_html_drained();
        write_pre_mode(1'b0);
        send_html_item(pth_pkg::CP_TAB, 1'b1, 1'b0);
        send_html_item('0, 1'b0, 1'b1);
    endtask

    task automatic test_random_texts(logic pre, int target, bit calm_in, bit calm_out);
        int start;
        wait_html_drained();
        write_pre_mode(pre);
        send_calm = calm_in;
        sink_calm = calm_out;
        start = items_sent;
        while (items_sent - start < target)
            send_random_text();
        send_calm = 1'b0;
        sink_calm = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_escapes_and_extremes();
        test_newline_runs();
        test_preformatted();
        test_random_texts(1'b0, 30, 1'b0, 1'b0);
        test_random_texts(1'b1, 30, 1'b1, 1'b1);
        test_random_texts(1'b1, 30, 1'b0, 1'b0);
        test_random_texts(1'b0, 30, 1'b1, 1'b0);
        wait_html_drained();

        if (html_expected.size() != 0)
            fail_count += html_expected.size();
        $display("sent %0d items over %0d texts in both whitespace modes", items_sent,
                 texts_done);
        $display("checked %0d output code points, %0d failures", html_checked, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
